// File: rtl/chull_pkg.sv
package chull_pkg;
   localparam int MaxPoints = 32;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int StackDepth = 2 * MaxPoints;
   localparam int StkW = $clog2(StackDepth);
   localparam int SpW = $clog2(StackDepth + 1);
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last_vertex;
      logic        empty_hull;
      logic        overflow;
   } result_type;
endpackage

// File: rtl/chull_queue.sv
module chull_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  chull_pkg::item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output chull_pkg::item_type   out_item
);
   chull_pkg::item_type mem_ff [chull_pkg::QDepth];
   logic [chull_pkg::QPtrW-1:0] wr_ff, rd_ff;
   logic [chull_pkg::QPtrW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (chull_pkg::QPtrW+1)'(chull_pkg::QDepth);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end
endmodule

// File: rtl/chull_engine.sv
module chull_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  chull_pkg::item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output chull_pkg::result_type out_res
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_INS, S_RUNSTART, S_FETCH, S_LOAD, S_CROSS, S_RDB, S_DECIDE,
      S_EMIT_RD, S_EMIT_WAIT, S_EMIT, S_EMPTY
   } state_type;
   state_type state_ff;

   logic [31:0] store_ff [chull_pkg::MaxPoints];
   logic [chull_pkg::IdxW-1:0] stack_ff [chull_pkg::StackDepth];
   logic [chull_pkg::CntW-1:0] count_ff, pos_ff, i_ff;
   logic [chull_pkg::SpW-1:0]  sp_ff, base_ff, k_ff;
   logic ovf_ff, last_ff, pass_ff;
   logic [31:0] key_ff, a_ff, b_ff, c_ff;
   logic [chull_pkg::IdxW-1:0] q_ff, sa_ff, sb_ff;
   logic signed [33:0] p1_ff, p2_ff;
   chull_pkg::result_type res_ff;
   logic res_v_ff;

   logic [31:0] key_in;
   logic signed [16:0] bx, by, cx, cy;
   logic [chull_pkg::IdxW-1:0] qn;
   logic [chull_pkg::IdxW-1:0] pos_idx;
   logic [chull_pkg::SpW-1:0]  sp_m1, sp_m2;
   logic res_free, res_load;

   assign key_in = {in_item.x ^ 16'h8000, in_item.y ^ 16'h8000};
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = res_v_ff;
   assign out_res = res_ff;

   assign bx = $signed({1'b0, b_ff[31:16]}) - $signed({1'b0, a_ff[31:16]});
   assign by = $signed({1'b0, b_ff[15:0]})  - $signed({1'b0, a_ff[15:0]});
   assign cx = $signed({1'b0, c_ff[31:16]}) - $signed({1'b0, a_ff[31:16]});
   assign cy = $signed({1'b0, c_ff[15:0]})  - $signed({1'b0, a_ff[15:0]});

   assign qn = pass_ff ? chull_pkg::IdxW'(count_ff - 1'b1 - i_ff) : chull_pkg::IdxW'(i_ff);
   assign pos_idx = pos_ff[chull_pkg::IdxW-1:0];
   assign sp_m1 = sp_ff - 1'b1;
   assign sp_m2 = sp_ff - 2'd2;

   assign res_free = !res_v_ff || out_ready;
   assign res_load = res_free && (state_ff == S_EMIT || state_ff == S_EMPTY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         res_v_ff <= 1'b0;
         sp_ff <= '0;
      end else begin
         if (res_load) res_v_ff <= 1'b1;
         else if (out_ready) res_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  key_ff <= key_in;
                  last_ff <= in_item.last;
                  pos_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (pos_ff < count_ff && store_ff[pos_idx] < key_ff) begin
                  pos_ff <= pos_ff + 1'b1;
               end else if (pos_ff < count_ff && store_ff[pos_idx] == key_ff) begin
                  state_ff <= last_ff ? S_RUNSTART : S_IDLE;
               end else if (count_ff < chull_pkg::CntW'(chull_pkg::MaxPoints)) begin
                  i_ff <= count_ff;
                  state_ff <= S_INS;
               end else begin
                  ovf_ff <= 1'b1;
                  state_ff <= last_ff ? S_RUNSTART : S_IDLE;
               end
            end
            S_INS: begin
               if (i_ff == pos_ff) begin
                  store_ff[pos_idx] <= key_ff;
                  count_ff <= count_ff + 1'b1;
                  state_ff <= last_ff ? S_RUNSTART : S_IDLE;
               end else begin
                  store_ff[chull_pkg::IdxW'(i_ff)] <= store_ff[chull_pkg::IdxW'(i_ff - 1'b1)];
                  i_ff <= i_ff - 1'b1;
               end
            end
            S_RUNSTART: begin
               if (count_ff < chull_pkg::CntW'(2)) begin
                  state_ff <= S_EMPTY;
               end else begin
                  sp_ff <= '0;
                  base_ff <= '0;
                  pass_ff <= 1'b0;
                  i_ff <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (i_ff == count_ff) begin
                  if (pass_ff) begin
                     sp_ff <= sp_m1;
                     k_ff <= '0;
                     state_ff <= S_EMIT_RD;
                  end else begin
                     sp_ff <= sp_m1;
                     base_ff <= sp_m1;
                     pass_ff <= 1'b1;
                     i_ff <= '0;
                  end
               end else begin
                  q_ff <= qn;
                  c_ff <= store_ff[qn];
                  if (sp_ff >= base_ff + 2'd2) begin
                     sa_ff <= stack_ff[sp_m2[chull_pkg::StkW-1:0]];
                     sb_ff <= stack_ff[sp_m1[chull_pkg::StkW-1:0]];
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_LOAD: begin
               a_ff <= store_ff[sa_ff];
               b_ff <= store_ff[sb_ff];
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               p1_ff <= bx * cy;
               p2_ff <= by * cx;
               state_ff <= S_RDB;
            end
            S_RDB: begin
               if (p1_ff > p2_ff) begin
                  sp_ff <= sp_m1;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               stack_ff[sp_ff[chull_pkg::StkW-1:0]] <= q_ff;
               sp_ff <= sp_ff + 1'b1;
               i_ff <= i_ff + 1'b1;
               state_ff <= S_FETCH;
            end
            S_EMIT_RD: begin
               sa_ff <= stack_ff[k_ff[chull_pkg::StkW-1:0]];
               state_ff <= S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
               a_ff <= store_ff[sa_ff];
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (res_free) begin
                  res_ff.x <= a_ff[31:16] ^ 16'h8000;
                  res_ff.y <= a_ff[15:0] ^ 16'h8000;
                  res_ff.last_vertex <= (k_ff + 1'b1 == sp_ff);
                  res_ff.empty_hull <= 1'b0;
                  res_ff.overflow <= ovf_ff;
                  if (k_ff + 1'b1 == sp_ff) begin
                     count_ff <= '0;
                     ovf_ff <= 1'b0;
                     sp_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            S_EMPTY: begin
               if (res_free) begin
                  res_ff <= '{16'h0, 16'h0, 1'b1, 1'b1, ovf_ff};
                  count_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/convex_hull_monotone_chain_unit.sv
// each point waits in the queue, then the engine does a sorted-insert scan and shift on it
// a hull run: a plain push is fetch, decide; a push after a cross test is fetch, load,
// cross, compare, decide; a pop is fetch, load, cross, compare;
// then each vertex out is read from stack and store and sent while the receiver is ready
// the engine takes one point at a time; a 4-deep queue absorbs input
// reset: synchronous, active high; clears counts, flags, queue and output valid
module convex_hull_monotone_chain_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // point_x, point_y
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // hull_x, hull_y
   output logic        rsp_tlast,   // last_vertex
   output logic [1:0]  rsp_tuser    // empty_hull, overflow
);
   chull_pkg::item_type   qin, qout;
   chull_pkg::result_type res;
   logic qv, qr;

   assign qin = '{req_tdata[15:0], req_tdata[31:16], req_tlast};

   chull_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(qin),
      .out_valid(qv), .out_ready(qr), .out_item(qout)
   );

   chull_engine u_engine (
      .clock, .reset,
      .in_valid(qv), .in_ready(qr), .in_item(qout),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {res.y, res.x};
   assign rsp_tlast = res.last_vertex;
   assign rsp_tuser = {res.overflow, res.empty_hull};
endmodule
